[rtl/core/lpht_pkg.sv]
// Shared constants and types for the linear probing hash table.
`default_nettype none

package lpht_pkg;

   // Table geometry
   localparam int TABLE_SIZE = 16;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int KEY_W      = 31;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 4;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_CHECK,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

[rtl/core/lpht_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none

module lpht_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, register the read every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/core/linear_probe_hash_table.sv]
// Linear probing hash table: one insert or search per transaction.
// Probing starts at the home slot and walks on with wrap-around until a result or until every
// slot is probed; each probe is a key store read and a compare.
// Throughput: one item at a time; the next request is taken in the cycle after the
// response transaction completes.
// Reset empties the table at once by clearing the slot valid flags; stored keys are
// not cleared.
`default_nettype none

module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [30:0] key, [31] zero
   input  wire logic        req_tuser,   // [0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [3:0] slot, [7:4] zero
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic                    op_ff, op_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [TABLE_SIZE-1:0]   valid_ff, valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;

   logic                    ram_we;
   logic [KEY_W-1:0]        ram_rdata;
   logic [IDX_W-1:0]        home_pos;
   logic [IDX_W-1:0]        next_pos;
   logic [31:0]             pos_wide;
   logic                    last_probe;
   logic                    key_match;

   lpht_ram #(
      .WIDTH  (KEY_W),
      .DEPTH  (TABLE_SIZE),
      .ADDR_W (IDX_W)
   ) u_key_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (pos_ff),
      .wdata (key_ff),
      .rdata (ram_rdata)
   );

   // Home slot, wrap-around successor and shared compare
   assign home_pos   = IDX_W'(req_tdata[KEY_W-1:0] % TABLE_SIZE);
   assign next_pos   = (pos_ff == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos_ff + 1'b1;
   assign last_probe = (cnt_ff == IDX_W'(TABLE_SIZE - 1));
   assign key_match  = (ram_rdata == key_ff);
   assign pos_wide   = 32'(pos_ff);

   // State and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

   // Probe sequencer
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      valid_in  = valid_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      ram_we    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // Capture the request and start at the home slot
            if (req_tvalid) begin
               op_in    = req_tuser;
               key_in   = req_tdata[KEY_W-1:0];
               pos_in   = home_pos;
               cnt_in   = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // Key store read of the current slot is in flight
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (op_ff == OP_INSERT && !valid_ff[pos_ff]) begin
               // Claim the empty slot
               ram_we           = 1'b1;
               valid_in[pos_ff] = 1'b1;
               status_in        = ST_INSERTED;
               slot_in          = pos_wide[SLOT_W-1:0];
               state_in         = S_RESP;
            end else if (op_ff == OP_SEARCH && !valid_ff[pos_ff]) begin
               status_in = ST_NOT_FOUND;
               slot_in   = '0;
               state_in  = S_RESP;
            end else if (op_ff == OP_SEARCH && key_match) begin
               status_in = ST_FOUND;
               slot_in   = pos_wide[SLOT_W-1:0];
               state_in  = S_RESP;
            end else if (last_probe) begin
               // Every slot probed once
               status_in = (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
               slot_in   = '0;
               state_in  = S_RESP;
            end else begin
               // Advance to the next slot
               pos_in   = next_pos;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_FETCH;
            end
         end
         S_RESP: begin
            // Hold the result until the transaction completes
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {4'b0000, slot_ff};
   assign rsp_tuser  = status_ff;

   // A pending result blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while a result is pending");

   // A key store write marks its slot occupied
   assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(pos_ff)])
      else $error("written slot not marked valid");

   // Full is only reported when every slot is occupied
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_FULL) |-> (&valid_ff))
      else $error("table full reported with an empty slot");

   // An inserted or found slot is occupied
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_INSERTED || rsp_tuser == ST_FOUND))
         |-> valid_ff[pos_ff])
      else $error("reported slot not valid");

endmodule

`default_nettype wire
